// File: hw/rtl/picture_unit_register_port_defines.svh
// Assertion macros for the picture unit register port.
// Included by the top level; no other dependencies.
`ifndef PICTURE_UNIT_REGISTER_PORT_DEFINES_SVH
`define PICTURE_UNIT_REGISTER_PORT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PUR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define PUR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pur_pkg.sv
// Shared types, codes and helper functions of the picture unit register port.
// No dependencies.
package pur_pkg;

   localparam int PATTERN_BYTES_DEF   = 8192;
   localparam int NAMETABLE_BYTES_DEF = 2048;
   localparam int SPRITE_BYTES_DEF    = 256;
   localparam int PALETTE_BYTES_DEF   = 32;

   localparam int ADDR_W = 15;

   // Item kinds
   localparam logic [2:0] REQ_READ      = 3'd0;
   localparam logic [2:0] REQ_WRITE     = 3'd1;
   localparam logic [2:0] REQ_VBLANK    = 3'd2;
   localparam logic [2:0] REQ_PRERENDER = 3'd3;
   localparam logic [2:0] REQ_SPRITE0   = 3'd4;

   // Register numbers
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   localparam logic [7:0]        MASK_RESET     = 8'h08;
   localparam logic [ADDR_W-1:0] PALETTE_START  = 15'h3F00;
   localparam logic [ADDR_W-1:0] NAMETABLE_BASE = 15'h2000;
   localparam logic [ADDR_W-1:0] COUNTER_KEEP   = 15'h701F;
   localparam logic [7:0]        CTRL_PRERENDER = 8'hFC;
   localparam logic [7:0]        NT_FILL_STEP   = 8'd207;

   typedef enum logic [1:0] {
      VM_PATTERN,
      VM_NAMETABLE,
      VM_PALETTE
   } vm_region_type;

   // Video memory access from the register core
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } vm_req_type;

   // Decode a cursor address into its mirrored region
   function automatic vm_region_type vm_region(input logic [ADDR_W-1:0] a);
      vm_region_type r;
      if (a[13:8] == 6'h3F) begin
         r = VM_PALETTE;
      end else if (a >= NAMETABLE_BASE) begin
         r = VM_NAMETABLE;
      end else begin
         r = VM_PATTERN;
      end
      return r;
   endfunction

   // Palette contents after reset
   function automatic logic [7:0] pal_reset(input int i);
      logic [7:0] v;
      unique case (i)
         0: v = 8'h0F;
         1: v = 8'h00;
         2: v = 8'h10;
         3: v = 8'h30;
         default: v = 8'((2 * i + 3) & 63);
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/pur_sprite_ram.sv
// Sprite memory: one write port, one registered read port.
// Depends on nothing.
module pur_sprite_ram #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pur_video_mem.sv
// Video memory: pattern and nametable RAMs, palette registers, mirroring.
// Depends on pur_pkg. Fills the nametable with its start pattern after reset.
module pur_video_mem
   import pur_pkg::*;
#(
   parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF,
   parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
   parameter int PALETTE_BYTES   = PALETTE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  vm_req_type vm_req,
   output logic [7:0] rd_data,
   output logic       init_done
);

   localparam int PAT_AW = $clog2(PATTERN_BYTES);
   localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_BYTES);

   logic [7:0] pat_mem [PATTERN_BYTES];
   logic [7:0] nt_mem  [NAMETABLE_BYTES];
   logic [7:0] pal_ff  [PALETTE_BYTES];

   logic [NT_AW:0]    init_cnt_ff;
   logic [7:0]        init_val_ff;
   logic [7:0]        pat_rd_ff, nt_rd_ff, pal_rd_ff;
   vm_region_type     region, region_ff;
   logic [PAL_AW-1:0] pal_rd_idx, pal_wr_idx;

   assign region    = vm_region(vm_req.addr);
   assign init_done = init_cnt_ff[NT_AW];

   // Palette mirrors: reads of backdrop slots see entry 0, writes to 0x10 go to 0
   always_comb begin
      pal_rd_idx = vm_req.addr[PAL_AW-1:0];
      if (pal_rd_idx[1:0] == 2'd0) begin
         pal_rd_idx = '0;
      end
      pal_wr_idx = vm_req.addr[PAL_AW-1:0];
      if (pal_wr_idx == PAL_AW'(PALETTE_BYTES / 2)) begin
         pal_wr_idx = '0;
      end
   end

   // Advance the nametable fill sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
         init_val_ff <= '0;
      end else if (!init_done) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         init_val_ff <= init_val_ff + NT_FILL_STEP;
      end
   end

   // Nametable RAM
   always_ff @(posedge clock) begin
      if (!init_done) begin
         nt_mem[init_cnt_ff[NT_AW-1:0]] <= init_val_ff;
      end else if (vm_req.wr && region == VM_NAMETABLE) begin
         nt_mem[vm_req.addr[NT_AW-1:0]] <= vm_req.wdata;
      end
      if (vm_req.rd) begin
         nt_rd_ff <= nt_mem[vm_req.addr[NT_AW-1:0]];
      end
   end

   // Pattern RAM
   always_ff @(posedge clock) begin
      if (vm_req.wr && region == VM_PATTERN) begin
         pat_mem[vm_req.addr[PAT_AW-1:0]] <= vm_req.wdata;
      end
      if (vm_req.rd) begin
         pat_rd_ff <= pat_mem[vm_req.addr[PAT_AW-1:0]];
      end
   end

   // Palette registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_BYTES; i++) begin
            pal_ff[i] <= pal_reset(i);
         end
      end else if (vm_req.wr && region == VM_PALETTE) begin
         pal_ff[pal_wr_idx] <= vm_req.wdata;
      end
   end

   // Hold the region and palette byte of the last read
   always_ff @(posedge clock) begin
      if (vm_req.rd) begin
         region_ff <= region;
         pal_rd_ff <= pal_ff[pal_rd_idx];
      end
   end

   always_comb begin
      unique case (region_ff)
         VM_NAMETABLE: rd_data = nt_rd_ff;
         VM_PALETTE:   rd_data = pal_rd_ff;
         default:      rd_data = pat_rd_ff;
      endcase
   end

endmodule

// File: hw/rtl/picture_unit_register_port.sv
// Top level of the picture unit register port: register core and handshakes.
// Depends on pur_pkg, pur_sprite_ram, pur_video_mem and the defines header.
//
//   channel | ports                              | direction
//   req     | req_valid/ready, type, index, data | in
//   rsp     | rsp_valid/ready, read data, state  | out
//
// Memories are read at acceptance of an item; the result and write-back follow
// when it leaves the work stage, and a new item enters only once that is empty.
// After reset the block takes no item while the nametable fills. A stalled
// rsp holds one item in the output register and one in the work stage;
// req_ready is low whenever the work stage holds an item.
`include "picture_unit_register_port_defines.svh"

module picture_unit_register_port
   import pur_pkg::*;
#(
   parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF,
   parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
   parameter int SPRITE_BYTES    = SPRITE_BYTES_DEF,
   parameter int PALETTE_BYTES   = PALETTE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_request,
   output logic [7:0]  rsp_control_byte,
   output logic [7:0]  rsp_mask_byte,
   output logic [4:0]  rsp_scroll_coarse_x,
   output logic [4:0]  rsp_scroll_coarse_y,
   output logic [2:0]  rsp_scroll_fine_x,
   output logic [2:0]  rsp_scroll_fine_y,
   output logic [14:0] rsp_video_address
);

   localparam int SPR_AW = $clog2(SPRITE_BYTES);

   // Architectural state
   logic [7:0]        ctrl_ff, ctrl_in;
   logic [7:0]        mask_ff, mask_in;
   logic [1:0]        status_ff, status_in;
   logic              toggle_ff, toggle_in;
   logic [SPR_AW-1:0] spr_addr_ff, spr_addr_in;
   logic [2:0]        fine_x_ff, fine_x_in, fine_y_ff, fine_y_in;
   logic [4:0]        coarse_x_ff, coarse_x_in, coarse_y_ff, coarse_y_in;
   logic [1:0]        nt_sel_ff, nt_sel_in;
   logic [14:0]       counter_ff, counter_in;
   logic [14:0]       cursor_ff, cursor_in, cursor_step;
   logic [7:0]        rbuf_ff, rbuf_in;

   // Work stage
   logic       s1_valid_ff;
   logic [2:0] s1_type_ff, s1_reg_ff;
   logic [7:0] s1_data_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [7:0]  rd_out_ff, rd_val;
   logic        nmi_out_ff, nmi_val;
   logic [7:0]  ctrl_out_ff, mask_out_ff;
   logic [4:0]  cx_out_ff, cy_out_ff;
   logic [2:0]  fx_out_ff, fy_out_ff;
   logic [14:0] cur_out_ff;

   logic       init_done, req_fire, s1_done;
   logic       spr_wr;
   logic [7:0] spr_rd_data, vm_rd_data;
   vm_req_type vm_req;

   assign req_ready = init_done && !s1_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign s1_done   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign cursor_step = cursor_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);

   // Issue memory reads at acceptance, write back at completion
   assign spr_wr = s1_done && s1_type_ff == REQ_WRITE && s1_reg_ff == REG_OAM_DATA;
   always_comb begin
      vm_req.rd    = req_fire && req_type == REQ_READ && req_reg_index == REG_DATA;
      vm_req.wr    = s1_done && s1_type_ff == REQ_WRITE && s1_reg_ff == REG_DATA;
      vm_req.addr  = cursor_ff;
      vm_req.wdata = s1_data_ff;
   end

   pur_sprite_ram #(
      .DEPTH (SPRITE_BYTES)
   ) u_sprite (
      .clock   (clock),
      .rd_en   (req_fire && req_type == REQ_READ && req_reg_index == REG_OAM_DATA),
      .rd_addr (spr_addr_ff),
      .wr_en   (spr_wr),
      .wr_addr (spr_addr_ff),
      .wr_data (s1_data_ff),
      .rd_data (spr_rd_data)
   );

   pur_video_mem #(
      .PATTERN_BYTES   (PATTERN_BYTES),
      .NAMETABLE_BYTES (NAMETABLE_BYTES),
      .PALETTE_BYTES   (PALETTE_BYTES)
   ) u_video (
      .clock     (clock),
      .reset     (reset),
      .vm_req    (vm_req),
      .rd_data   (vm_rd_data),
      .init_done (init_done)
   );

   // Compute the item's effect on the registers
   always_comb begin
      ctrl_in     = ctrl_ff;
      mask_in     = mask_ff;
      status_in   = status_ff;
      toggle_in   = toggle_ff;
      spr_addr_in = spr_addr_ff;
      fine_x_in   = fine_x_ff;
      fine_y_in   = fine_y_ff;
      coarse_x_in = coarse_x_ff;
      coarse_y_in = coarse_y_ff;
      nt_sel_in   = nt_sel_ff;
      counter_in  = counter_ff;
      cursor_in   = cursor_ff;
      rbuf_in     = rbuf_ff;
      rd_val      = '0;
      nmi_val     = 1'b0;
      unique case (s1_type_ff)
         REQ_READ: begin
            unique case (s1_reg_ff)
               REG_STATUS: begin
                  rd_val    = {status_ff, 6'd0};
                  status_in = '0;
                  toggle_in = 1'b1;
               end
               REG_OAM_DATA: begin
                  rd_val      = spr_rd_data;
                  spr_addr_in = spr_addr_ff + 1'b1;
               end
               REG_DATA: begin
                  if (cursor_ff >= PALETTE_START) begin
                     rd_val = vm_rd_data;
                  end else begin
                     rd_val  = rbuf_ff;
                     rbuf_in = vm_rd_data;
                  end
                  cursor_in = cursor_step;
               end
               default: ;
            endcase
         end
         REQ_WRITE: begin
            unique case (s1_reg_ff)
               REG_CTRL:     ctrl_in     = s1_data_ff;
               REG_MASK:     mask_in     = s1_data_ff;
               REG_OAM_ADDR: spr_addr_in = s1_data_ff[SPR_AW-1:0];
               REG_OAM_DATA: spr_addr_in = spr_addr_ff + 1'b1;
               REG_SCROLL: begin
                  if (toggle_ff) begin
                     fine_x_in   = s1_data_ff[2:0];
                     coarse_x_in = s1_data_ff[7:3];
                  end else begin
                     fine_y_in   = s1_data_ff[2:0];
                     coarse_y_in = s1_data_ff[7:3];
                  end
                  toggle_in = !toggle_ff;
               end
               REG_ADDR: begin
                  if (toggle_ff) begin
                     fine_y_in   = {1'b0, s1_data_ff[5:4]};
                     nt_sel_in   = {s1_data_ff[3], s1_data_ff[2]};
                     coarse_y_in = {s1_data_ff[1:0], coarse_y_ff[2:0]};
                  end else begin
                     coarse_y_in = {coarse_y_ff[4:3], s1_data_ff[7:5]};
                     coarse_x_in = s1_data_ff[4:0];
                     counter_in  = {fine_y_ff, nt_sel_ff, coarse_y_in, coarse_x_in};
                  end
                  toggle_in = !toggle_ff;
                  cursor_in = counter_in;
               end
               REG_DATA: cursor_in = cursor_step;
               default: ;
            endcase
         end
         REQ_VBLANK: begin
            status_in  = status_ff | 2'b10;
            counter_in = counter_ff & COUNTER_KEEP;
            nt_sel_in  = '0;
            nmi_val    = ctrl_ff[7];
         end
         REQ_PRERENDER: begin
            ctrl_in   = ctrl_ff & CTRL_PRERENDER;
            status_in = '0;
         end
         REQ_SPRITE0: status_in = status_ff | 2'b01;
         default: ;
      endcase
   end

   // Hold state, advance on completion
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         mask_ff      <= MASK_RESET;
         status_ff    <= '0;
         toggle_ff    <= 1'b1;
         spr_addr_ff  <= '0;
         fine_x_ff    <= '0;
         fine_y_ff    <= '0;
         coarse_x_ff  <= '0;
         coarse_y_ff  <= '0;
         nt_sel_ff    <= '0;
         counter_ff   <= '0;
         cursor_ff    <= '0;
         rbuf_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_done) begin
            ctrl_ff     <= ctrl_in;
            mask_ff     <= mask_in;
            status_ff   <= status_in;
            toggle_ff   <= toggle_in;
            spr_addr_ff <= spr_addr_in;
            fine_x_ff   <= fine_x_in;
            fine_y_ff   <= fine_y_in;
            coarse_x_ff <= coarse_x_in;
            coarse_y_ff <= coarse_y_in;
            nt_sel_ff   <= nt_sel_in;
            counter_ff  <= counter_in;
            cursor_ff   <= cursor_in;
            rbuf_ff     <= rbuf_in;
         end
      end
   end

   // Capture the item and the result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff <= req_type;
         s1_reg_ff  <= req_reg_index;
         s1_data_ff <= req_write_data;
      end
      if (s1_done) begin
         rd_out_ff   <= rd_val;
         nmi_out_ff  <= nmi_val;
         ctrl_out_ff <= ctrl_in;
         mask_out_ff <= mask_in;
         cx_out_ff   <= coarse_x_in;
         cy_out_ff   <= coarse_y_in;
         fx_out_ff   <= fine_x_in;
         fy_out_ff   <= fine_y_in;
         cur_out_ff  <= cursor_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rd_out_ff;
   assign rsp_nmi_request     = nmi_out_ff;
   assign rsp_control_byte    = ctrl_out_ff;
   assign rsp_mask_byte       = mask_out_ff;
   assign rsp_scroll_coarse_x = cx_out_ff;
   assign rsp_scroll_coarse_y = cy_out_ff;
   assign rsp_scroll_fine_x   = fx_out_ff;
   assign rsp_scroll_fine_y   = fy_out_ff;
   assign rsp_video_address   = cur_out_ff;

   `PUR_ASSERT_NEXT(a_fire_busy, req_fire, s1_valid_ff && !req_ready, "accepted item not held")
   `PUR_ASSERT_NEXT(a_done_out, s1_done, rsp_valid_ff, "finished item not presented")
   `PUR_ASSERT_SAME(a_init_idle, !init_done, !s1_valid_ff && !rsp_valid_ff, "item during fill")
   `PUR_ASSERT_SAME(a_mem_excl, vm_req.rd, !vm_req.wr, "video read and write collide")

endmodule

// File: test/picture_unit_register_port_tb.sv
// Self-checking testbench for the picture unit register port.
// Depends on pur_pkg and the picture_unit_register_port RTL.
`timescale 1ns / 100ps

module picture_unit_register_port_tb;
   import pur_pkg::*;

   typedef struct packed {
      logic [7:0]  rd;
      logic        nmi;
      logic [7:0]  ctrl;
      logic [7:0]  mask;
      logic [4:0]  cx;
      logic [4:0]  cy;
      logic [2:0]  fx;
      logic [2:0]  fy;
      logic [14:0] vaddr;
   } port_state_type;

   typedef struct packed {
      logic           drain;
      logic [2:0]     kind;
      logic [2:0]     idx;
      logic [7:0]     data;
      port_state_type want;
   } bus_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_reg_index = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_request;
   logic [7:0]  rsp_control_byte;
   logic [7:0]  rsp_mask_byte;
   logic [4:0]  rsp_scroll_coarse_x;
   logic [4:0]  rsp_scroll_coarse_y;
   logic [2:0]  rsp_scroll_fine_x;
   logic [2:0]  rsp_scroll_fine_y;
   logic [14:0] rsp_video_address;

   picture_unit_register_port uut (.*);

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the register port
   logic [7:0]  sh_ctrl, sh_mask, sh_oam_addr, sh_rbuf;
   logic [1:0]  sh_flags, sh_nt;
   logic        sh_toggle;
   logic [2:0]  sh_fx, sh_fy;
   logic [4:0]  sh_cx, sh_cy;
   logic [14:0] sh_counter, sh_cursor;
   logic [7:0]  sh_oam [256];
   logic        oam_known [256];
   logic [7:0]  sh_pat [8192];
   logic        pat_known [8192];
   logic [7:0]  sh_nt_mem [2048];
   logic [7:0]  sh_pal [32];

   bus_item_type   pending_items[$];
   port_state_type expected_state[$];
   int             fails = 0;
   int             seen = 0;

   function automatic logic [14:0] fold_addr(input logic [14:0] a);
      if (a[13:8] == 6'h3F) return 15'h3F00 | {10'h000, a[4:0]};
      if (a >= 15'h2800) return 15'h2000 | {4'h0, a[10:0]};
      return a;
   endfunction

   // Read a folded video address from the shadow memories
   function automatic logic [7:0] vm_peek(input logic [14:0] m);
      if (m[13:8] == 6'h3F) return sh_pal[m[4:0]];
      if (m >= 15'h2000) return sh_nt_mem[m[10:0]];
      return sh_pat[m[12:0]];
   endfunction

   function automatic logic read_allowed(input logic [2:0] r);
      logic [14:0] m;
      m = fold_addr(sh_cursor);
      if (r == REG_OAM_DATA) return oam_known[sh_oam_addr];
      if (r == REG_DATA && sh_cursor < 15'h3F00 && m < 15'h2000) return pat_known[m[12:0]];
      return 1'b1;
   endfunction

   task automatic step_cursor();
      sh_cursor = sh_cursor + (sh_ctrl[2] ? 15'd32 : 15'd1);
   endtask

   task automatic init_shadow();
      sh_ctrl = '0; sh_mask = MASK_RESET; sh_flags = '0; sh_toggle = 1'b1;
      sh_oam_addr = '0; sh_fx = '0; sh_fy = '0; sh_cx = '0; sh_cy = '0; sh_nt = '0;
      sh_counter = '0; sh_cursor = '0; sh_rbuf = '0;
      for (int i = 0; i < 256; i++) oam_known[i] = 1'b0;
      for (int i = 0; i < 8192; i++) pat_known[i] = 1'b0;
      for (int i = 0; i < 2048; i++) sh_nt_mem[i] = 8'((1231 * i) & 255);
      for (int i = 0; i < 32; i++) sh_pal[i] = 8'((2 * i + 3) & 63);
      sh_pal[0] = 8'h0F; sh_pal[1] = 8'h00; sh_pal[2] = 8'h10; sh_pal[3] = 8'h30;
   endtask

   // Apply one item to the shadow and report the resulting port state
   task automatic predict_port(input logic [2:0] kind, input logic [2:0] r,
                               input logic [7:0] d, output port_state_type s);
      logic [14:0] m;
      s = '0;
      case (kind)
         REQ_READ: begin
            case (r)
               REG_STATUS: begin
                  s.rd = {sh_flags, 6'b0}; sh_flags = '0; sh_toggle = 1'b1;
               end
               REG_OAM_DATA: begin
                  s.rd = sh_oam[sh_oam_addr]; sh_oam_addr++;
               end
               REG_DATA: begin
                  m = fold_addr(sh_cursor);
                  if (sh_cursor >= 15'h3F00) begin
                     if (m[13:8] == 6'h3F && m[1:0] == 2'b00) m = PALETTE_START;
                     s.rd = vm_peek(m);
                  end else begin
                     s.rd = sh_rbuf; sh_rbuf = vm_peek(m);
                  end
                  step_cursor();
               end
               default: ;
            endcase
         end
         REQ_WRITE: begin
            case (r)
               REG_CTRL: sh_ctrl = d;
               REG_MASK: sh_mask = d;
               REG_OAM_ADDR: sh_oam_addr = d;
               REG_OAM_DATA: begin
                  sh_oam[sh_oam_addr] = d; oam_known[sh_oam_addr] = 1'b1; sh_oam_addr++;
               end
               REG_SCROLL: begin
                  if (sh_toggle) begin
                     sh_fx = d[2:0]; sh_cx = d[7:3];
                  end else begin
                     sh_fy = d[2:0]; sh_cy = d[7:3];
                  end
                  sh_toggle = ~sh_toggle;
               end
               REG_ADDR: begin
                  if (sh_toggle) begin
                     sh_fy = {1'b0, d[5:4]}; sh_nt = {d[3], d[2]}; sh_cy = {d[1:0], sh_cy[2:0]};
                  end else begin
                     sh_cy = {sh_cy[4:3], d[7:5]}; sh_cx = d[4:0];
                     sh_counter = {sh_fy, sh_nt, sh_cy, sh_cx};
                  end
                  sh_toggle = ~sh_toggle;
                  sh_cursor = sh_counter;
               end
               REG_DATA: begin
                  m = fold_addr(sh_cursor);
                  if (m == 15'h3F10) m = PALETTE_START;
                  if (m[13:8] == 6'h3F) sh_pal[m[4:0]] = d;
                  else if (m >= 15'h2000) sh_nt_mem[m[10:0]] = d;
                  else begin
                     sh_pat[m[12:0]] = d; pat_known[m[12:0]] = 1'b1;
                  end
                  step_cursor();
               end
               default: ;
            endcase
         end
         REQ_VBLANK: begin
            sh_flags[1] = 1'b1; sh_counter &= COUNTER_KEEP; sh_nt = '0; s.nmi = sh_ctrl[7];
         end
         REQ_PRERENDER: begin
            sh_ctrl &= CTRL_PRERENDER; sh_flags = '0;
         end
         REQ_SPRITE0: sh_flags[0] = 1'b1;
         default: ;
      endcase
      s.ctrl = sh_ctrl; s.mask = sh_mask; s.cx = sh_cx; s.cy = sh_cy;
      s.fx = sh_fx; s.fy = sh_fy; s.vaddr = sh_cursor;
   endtask

   // Queue one item; a read of never written memory becomes a write instead
   task automatic add_item(input logic [2:0] kind, input logic [2:0] r, input logic [7:0] d);
      bus_item_type it;
      if (kind == REQ_READ && !read_allowed(r)) kind = REQ_WRITE;
      it.drain = 1'b0; it.kind = kind; it.idx = r; it.data = d;
      predict_port(kind, r, d, it.want);
      pending_items.push_back(it);
   endtask

   task automatic add_drain();
      bus_item_type it;
      it = '0; it.drain = 1'b1;
      pending_items.push_back(it);
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Accept flag sampled at the rising edge
   logic req_fire;
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   // Driver: offer items from the pending queue at the falling edge
   int  req_gap = 0;
   logic calm_phase = 1'b0;
   always @(negedge clock) begin
      bus_item_type nx;
      logic         offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold until accepted
      end else begin
         offer = 1'b0;
         if (req_valid && req_fire) begin
            nx = pending_items.pop_front();
            expected_state.push_back(nx.want);
         end
         if ($urandom_range(0, 199) == 0) calm_phase = ~calm_phase;
         if (pending_items.size() > 0 && pending_items[0].drain) begin
            if (expected_state.size() == 0) void'(pending_items.pop_front());
         end else if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() > 0) begin
            nx = pending_items[0];
            offer = 1'b1;
            req_type <= nx.kind; req_reg_index <= nx.idx; req_write_data <= nx.data;
            req_gap = calm_phase ? 0 : pick_gap();
         end
         req_valid <= offer;
      end
   end

   // Receiver readiness, with one long hold-off partway through
   int rsp_gap = 0;
   int hold_left = 0;
   logic held_once = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!held_once && seen >= 300) begin
         held_once = 1'b1; hold_left = 400; rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--; rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--; rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_phase) rsp_gap = pick_gap();
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      port_state_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_read_data, rsp_nmi_request, rsp_control_byte, rsp_mask_byte,
                rsp_scroll_coarse_x, rsp_scroll_coarse_y, rsp_scroll_fine_x,
                rsp_scroll_fine_y, rsp_video_address};
         seen++;
         if (expected_state.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            fails++;
         end else begin
            want = expected_state.pop_front();
            if (got.rd !== want.rd || got.nmi !== want.nmi || got.ctrl !== want.ctrl ||
                got.mask !== want.mask || got.cx !== want.cx || got.cy !== want.cy ||
                got.fx !== want.fx || got.fy !== want.fy || got.vaddr !== want.vaddr) begin
               $display("%0t result mismatch: expected %h actual %h", $time, want, got);
               fails++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int n, p;
      init_shadow();
      // directed: every register read and write, events, mirroring, wrap
      for (int r = 0; r < 8; r++) add_item(REQ_READ, 3'(r), 8'h00);
      add_item(REQ_WRITE, REG_CTRL, 8'h84);
      add_item(REQ_WRITE, REG_MASK, 8'hFF);
      add_item(REQ_WRITE, REG_STATUS, 8'hFF);
      add_item(REQ_WRITE, REG_OAM_ADDR, 8'hFF);
      add_item(REQ_WRITE, REG_OAM_DATA, 8'hA5);
      add_item(REQ_SPRITE0, 3'd7, 8'hFF);
      add_item(REQ_VBLANK, 3'd0, 8'h00);
      add_item(REQ_READ, REG_STATUS, 8'h00);
      add_item(REQ_WRITE, REG_ADDR, 8'h3F);
      add_item(REQ_WRITE, REG_SCROLL, 8'hFF);
      add_item(REQ_WRITE, REG_SCROLL, 8'h00);
      add_item(REQ_WRITE, REG_ADDR, 8'hFF);
      add_item(REQ_READ, REG_DATA, 8'h00);
      add_item(REQ_WRITE, REG_ADDR, 8'h3F);
      add_item(REQ_WRITE, REG_ADDR, 8'h10);
      add_item(REQ_WRITE, REG_DATA, 8'h2A);
      add_item(REQ_PRERENDER, 3'd0, 8'h00);
      add_item(REQ_READ, REG_DATA, 8'h00);
      add_item(3'd7, 3'd5, 8'h55);
      add_drain();
      // random: mostly well-formed register sequences
      while (pending_items.size() < 1700) begin
         p = $urandom_range(0, 99);
         if (p < 30) begin
            add_item(REQ_READ, REG_STATUS, 8'h00);
            add_item(REQ_WRITE, REG_ADDR, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 63)));
            add_item(REQ_WRITE, REG_ADDR, 8'($urandom));
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
               add_item($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, REG_DATA, 8'($urandom));
         end else if (p < 42) begin
            add_item(REQ_WRITE, REG_OAM_ADDR, 8'($urandom));
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
               add_item($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, REG_OAM_DATA, 8'($urandom));
         end else if (p < 50) begin
            add_item(REQ_WRITE, REG_SCROLL, 8'($urandom));
            add_item(REQ_WRITE, REG_SCROLL, 8'($urandom));
         end else if (p < 57) begin
            add_item(3'($urandom_range(2, 4)), 3'($urandom), 8'($urandom));
         end else begin
            add_item(3'($urandom_range(0, 7)), 3'($urandom), 8'($urandom));
         end
         if ($urandom_range(0, 299) == 0) add_drain();
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || req_valid || expected_state.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fails == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
